[rtl/hct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hct_pkg;

  localparam logic [31:0] HASH_MULT = 32'h0100_0193;
  localparam logic [31:0] HASH_SEED = 32'h811C_9DC5;

  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    KIND_REG    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    IDX_NONE  = 2'd0,
    IDX_COUNT = 2'd1,
    IDX_MATCH = 2'd2
  } idx_sel_e;

  typedef struct packed {
    logic     accept;
    logic     clear;
    logic     search_start;
    logic     search_step;
    logic     wr_reg;
    logic     wr_upd;
    logic     res_load;
    status_e  res_status;
    idx_sel_e res_idx;
    logic     res_lookup;
    logic     out_load;
  } hct_ctl_t;

  typedef struct packed {
    kind_e op_kind;
    logic  full;
    logic  empty;
    logic  hit;
    logic  miss;
  } hct_sts_t;

  function automatic logic [31:0] fnv_fold(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * HASH_MULT;
  endfunction

endpackage

`default_nettype wire

[rtl/hashed_command_table.sv]
// Hashed command table.
// Slave stream: one transfer per token byte or table operation.
//   tuser = kind, token_select; tlast = token_end; tdata carries the byte,
//   handler fields, update hash pairs and has_args.
// Master stream: one transfer per operation result (status, found_handler,
//   entry_index, pass_args); byte transfers that do not close a parameter
//   token give no result.
// A token byte is folded into the running hash as it is taken (FNV-1a,
//   one 32-bit multiply). A register writes its entry in the write state,
//   then its result goes to the output register; a table clear or a
//   full/empty report loads its result when taken. A lookup or update walks
//   the table through its single read port, one entry per cycle.
// Input is taken only while no operation is in progress; the result sits in
//   the output register, so the next item is taken while it waits.
// A stalled master holds the result; a further result then waits in the
//   block until the output register frees.
// Reset empties the table (entry count to zero) and restarts the hash; no
//   clearing pass over the storage is needed.
`timescale 1ns / 1ps
`default_nettype none

module hashed_command_table #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned HANDLER_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // data_byte[7:0], handler_id[15:8], handler_valid[16], old_cmd_hash[48:17],
  // old_param_hash[80:49], new_cmd_hash[112:81], new_param_hash[144:113],
  // has_args[145], zero fill [151:146]
  input  wire logic [hct_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // kind[1:0], token_select[2]
  input  wire logic [hct_pkg::IN_USER_W-1:0] s_axis_tuser_i,
  input  wire logic                          s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // status[1:0], found_handler[9:2], entry_index[15:10], pass_args[16],
  // zero fill [23:17]
  output logic [hct_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);
  import hct_pkg::*;

  hct_ctl_t ctl;
  hct_sts_t sts;
  kind_e    in_kind;

  assign in_kind = kind_e'(s_axis_tuser_i[1:0]);

  hct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .in_kind_i  (in_kind),
    .in_sel_i   (s_axis_tuser_i[2]),
    .in_last_i  (s_axis_tlast_i),
    .s_tready_o (s_axis_tready_o),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  hct_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .HANDLER_BITS (HANDLER_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .s_tlast_i (s_axis_tlast_i),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .m_tdata_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

[rtl/hct_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module hct_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_tvalid_i,
  input  wire hct_pkg::kind_e   in_kind_i,
  input  wire logic             in_sel_i,
  input  wire logic             in_last_i,
  output logic                  s_tready_o,
  input  wire logic             m_tready_i,
  output logic                  m_tvalid_o,
  input  wire hct_pkg::hct_sts_t sts_i,
  output hct_pkg::hct_ctl_t     ctl_o
);
  import hct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_SEARCH,
    S_EMIT
  } state_e;

  state_e   state_q, state_d;
  logic     m_tvalid_q, m_tvalid_d;
  hct_ctl_t ctl;

  always_comb begin
    ctl     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          ctl.accept = 1'b1;
          unique case (in_kind_i)
            KIND_CLEAR: begin
              ctl.clear      = 1'b1;
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_OK;
              ctl.res_idx    = IDX_NONE;
              state_d        = S_EMIT;
            end
            KIND_UPDATE: begin
              if (sts_i.empty) begin
                ctl.res_load   = 1'b1;
                ctl.res_status = ST_EMPTY;
                ctl.res_idx    = IDX_NONE;
                state_d        = S_EMIT;
              end else begin
                ctl.search_start = 1'b1;
                state_d          = S_SEARCH;
              end
            end
            KIND_REG: begin
              if (in_last_i && in_sel_i) begin
                if (sts_i.full) begin
                  ctl.res_load   = 1'b1;
                  ctl.res_status = ST_FULL;
                  ctl.res_idx    = IDX_NONE;
                  state_d        = S_EMIT;
                end else begin
                  state_d = S_WRITE;
                end
              end
            end
            KIND_LOOKUP: begin
              if (in_last_i && in_sel_i) begin
                if (sts_i.empty) begin
                  ctl.res_load   = 1'b1;
                  ctl.res_status = ST_EMPTY;
                  ctl.res_idx    = IDX_NONE;
                  state_d        = S_EMIT;
                end else begin
                  ctl.search_start = 1'b1;
                  state_d          = S_SEARCH;
                end
              end
            end
          endcase
        end
      end
      S_WRITE: begin
        ctl.wr_reg     = 1'b1;
        ctl.res_load   = 1'b1;
        ctl.res_status = ST_OK;
        ctl.res_idx    = IDX_COUNT;
        state_d        = S_EMIT;
      end
      S_SEARCH: begin
        if (sts_i.hit) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ST_OK;
          ctl.res_idx    = IDX_MATCH;
          if (sts_i.op_kind == KIND_UPDATE) begin
            ctl.wr_upd = 1'b1;
          end else begin
            ctl.res_lookup = 1'b1;
          end
          state_d = S_EMIT;
        end else if (sts_i.miss) begin
          ctl.res_load   = 1'b1;
          ctl.res_idx    = IDX_NONE;
          ctl.res_status = (sts_i.op_kind == KIND_UPDATE) ? ST_OK : ST_NOTFOUND;
          state_d        = S_EMIT;
        end else begin
          ctl.search_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (!m_tvalid_q || m_tready_i) begin
          ctl.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    if (ctl.out_load) begin
      m_tvalid_d = 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_d = 1'b0;
    end else begin
      m_tvalid_d = m_tvalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = m_tvalid_q;
  assign ctl_o      = ctl;

endmodule

`default_nettype wire

[rtl/hct_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module hct_datapath #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned HANDLER_BITS = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [hct_pkg::IN_DATA_W-1:0]   s_tdata_i,
  input  wire logic [hct_pkg::IN_USER_W-1:0]   s_tuser_i,
  input  wire logic                            s_tlast_i,
  input  wire hct_pkg::hct_ctl_t               ctl_i,
  output hct_pkg::hct_sts_t                    sts_o,
  output logic [hct_pkg::OUT_DATA_W-1:0]       m_tdata_o
);
  import hct_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned XW = (IW > 6) ? IW : 6;

  // input fields
  kind_e       in_kind;
  logic        in_sel;
  logic [7:0]  in_byte;
  logic [7:0]  in_hid;
  logic        in_hval;
  logic [31:0] in_old_c, in_old_p, in_new_c, in_new_p;
  logic        in_args;

  assign in_kind  = kind_e'(s_tuser_i[1:0]);
  assign in_sel   = s_tuser_i[2];
  assign in_byte  = s_tdata_i[7:0];
  assign in_hid   = s_tdata_i[15:8];
  assign in_hval  = s_tdata_i[16];
  assign in_old_c = s_tdata_i[48:17];
  assign in_old_p = s_tdata_i[80:49];
  assign in_new_c = s_tdata_i[112:81];
  assign in_new_p = s_tdata_i[144:113];
  assign in_args  = s_tdata_i[145];

  // table storage
  logic [31:0]             mem_cmd [TABLE_DEPTH];
  logic [31:0]             mem_param [TABLE_DEPTH];
  logic [HANDLER_BITS-1:0] mem_hnd [TABLE_DEPTH];

  logic [CW-1:0] count_q, count_d;
  logic [31:0]   hash_q, hash_d;
  logic [31:0]   held_q, held_d;
  logic [CW-1:0] srch_idx_q, srch_idx_d;
  logic          cmp_vld_q, cmp_vld_d;

  logic [IW-1:0]           cmp_idx_q;
  logic [31:0]             key_cmd_q, key_param_q;
  logic [31:0]             new_c_q, new_p_q;
  logic [HANDLER_BITS-1:0] hid_q;
  logic                    hval_q, args_q;
  kind_e                   kind_q;

  logic [31:0]             rd_cmd_q, rd_param_q;
  logic [HANDLER_BITS-1:0] rd_hnd_q;

  status_e                 res_status_q;
  logic [IW-1:0]           res_idx_q;
  logic [HANDLER_BITS-1:0] res_hnd_q;
  logic                    res_args_q;
  logic [OUT_DATA_W-1:0]   out_data_q;

  logic [31:0]             fold;
  logic                    byte_kind;
  logic                    issue;
  logic                    match;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic [31:0]             wr_cmd, wr_param;
  logic [HANDLER_BITS-1:0] wr_hnd;
  logic [IW-1:0]           res_idx_d;
  logic [XW-1:0]           out_idx_ext;

  assign fold      = fnv_fold(hash_q, in_byte);
  assign byte_kind = (in_kind == KIND_REG) || (in_kind == KIND_LOOKUP);
  assign issue     = ctl_i.search_step && (srch_idx_q < count_q);
  assign match     = cmp_vld_q && (rd_cmd_q == key_cmd_q) && (rd_param_q == key_param_q);

  always_comb begin
    count_d    = count_q;
    hash_d     = hash_q;
    held_d     = held_q;
    srch_idx_d = srch_idx_q;
    cmp_vld_d  = issue;
    if (ctl_i.clear) begin
      count_d = '0;
      hash_d  = HASH_SEED;
      held_d  = '0;
    end else if (ctl_i.accept && byte_kind) begin
      if (s_tlast_i) begin
        hash_d = HASH_SEED;
        if (!in_sel) begin
          held_d = fold;
        end
      end else begin
        hash_d = fold;
      end
    end
    if (ctl_i.wr_reg) begin
      count_d = count_q + CW'(1);
    end
    if (ctl_i.search_start) begin
      srch_idx_d = '0;
    end else if (issue) begin
      srch_idx_d = srch_idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      hash_q     <= HASH_SEED;
      held_q     <= '0;
      srch_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
    end else begin
      count_q    <= count_d;
      hash_q     <= hash_d;
      held_q     <= held_d;
      srch_idx_q <= srch_idx_d;
      cmp_vld_q  <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      kind_q  <= in_kind;
      hid_q   <= HANDLER_BITS'(in_hid);
      hval_q  <= in_hval;
      args_q  <= in_args;
      new_c_q <= in_new_c;
      new_p_q <= in_new_p;
      if (in_kind == KIND_UPDATE) begin
        key_cmd_q   <= in_old_c;
        key_param_q <= in_old_p;
      end else begin
        key_cmd_q   <= held_q;
        key_param_q <= fold;
      end
    end
    if (ctl_i.search_step) begin
      cmp_idx_q <= srch_idx_q[IW-1:0];
    end
  end

  // single write port, single registered read port
  assign wr_en    = ctl_i.wr_reg || ctl_i.wr_upd;
  assign wr_addr  = ctl_i.wr_upd ? cmp_idx_q : count_q[IW-1:0];
  assign wr_cmd   = ctl_i.wr_upd ? new_c_q : key_cmd_q;
  assign wr_param = ctl_i.wr_upd ? new_p_q : key_param_q;
  assign wr_hnd   = (ctl_i.wr_upd && !hval_q) ? rd_hnd_q : hid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_cmd[wr_addr]   <= wr_cmd;
      mem_param[wr_addr] <= wr_param;
      mem_hnd[wr_addr]   <= wr_hnd;
    end
    if (issue) begin
      rd_cmd_q   <= mem_cmd[srch_idx_q[IW-1:0]];
      rd_param_q <= mem_param[srch_idx_q[IW-1:0]];
      rd_hnd_q   <= mem_hnd[srch_idx_q[IW-1:0]];
    end
  end

  always_comb begin
    unique case (ctl_i.res_idx)
      IDX_COUNT: res_idx_d = count_q[IW-1:0];
      IDX_MATCH: res_idx_d = cmp_idx_q;
      default:   res_idx_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      res_status_q <= ctl_i.res_status;
      res_idx_q    <= res_idx_d;
      res_hnd_q    <= ctl_i.res_lookup ? rd_hnd_q : '0;
      res_args_q   <= ctl_i.res_lookup && args_q;
    end
    if (ctl_i.out_load) begin
      out_data_q <= {7'd0, res_args_q, out_idx_ext[5:0], 8'(res_hnd_q), res_status_q};
    end
  end

  assign out_idx_ext = XW'(res_idx_q);

  assign sts_o.op_kind = kind_q;
  assign sts_o.full    = (count_q == CW'(TABLE_DEPTH));
  assign sts_o.empty   = (count_q == '0);
  assign sts_o.hit     = match;
  assign sts_o.miss    = cmp_vld_q && !match && ((CW'(cmp_idx_q) + CW'(1)) == count_q);

  assign m_tdata_o = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_reg_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.wr_reg |-> (count_q < CW'(TABLE_DEPTH)))
    else $error("register write into full table");

  a_hit_miss_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts_o.hit && sts_o.miss))
    else $error("search hit and miss together");

  a_search_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.search_step |-> (count_q != '0))
    else $error("search of empty table");

endmodule

`default_nettype wire
